>>> rtl/record_deframer_crc32_check_macros.svh
// Assertion macros shared by the record deframer RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef RECORD_DEFRAMER_CRC32_CHECK_MACROS_SVH
`define RECORD_DEFRAMER_CRC32_CHECK_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define RDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property that also holds during reset.
`define RDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/rdc_pkg.sv
// Types, codes and the CRC-32 byte update for the record deframer.
// No dependencies; imported by every module of the block.
package rdc_pkg;

  // Header and trailer geometry
  localparam int unsigned HDR_BYTES = 16;
  localparam int unsigned CRC_BYTES = 4;

  // Defaults and sizes
  localparam int unsigned LEN_BITS_DEF  = 32;
  localparam int unsigned OUT_DEPTH_DEF = 8;
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [31:0] MAGIC_RESET   = 32'h5245_4331;
  localparam logic [15:0] VERSION_RESET = 16'd1;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;

  // Record types accepted
  localparam logic [15:0] TYPE_PUT    = 16'd1;
  localparam logic [15:0] TYPE_DELETE = 16'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_VERSION = 1'b1;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_CRC         = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [15:0] record_kind;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [33:0] bytes_consumed;
    logic        last;
  } out_word_t;

  // Up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  // Reflected CRC-32 update over one byte, LSB first
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

>>> rtl/record_deframer_crc32_check.sv
// Record deframer with CRC-32 check: byte in, key/value bytes and verdicts out.
// Each accepted byte is registered; its results are then queued for output.
// Throughput: one byte per cycle; a byte that ends a buffer inside the payload
// gives two results, and the result queue stalls the input when its fill plus
// the word in the input register nears depth.
// Reset clears record state and the queue and loads the default magic and version.
module record_deframer_crc32_check #(
  parameter int unsigned LEN_BITS  = rdc_pkg::LEN_BITS_DEF,
  parameter int unsigned OUT_DEPTH = rdc_pkg::OUT_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rdc_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rdc_pkg::out_word_t              out_data_o
);
  import rdc_pkg::*;

  localparam int unsigned LVL_W = $clog2(OUT_DEPTH + 1);

  logic             accept;
  logic             busy;
  push_t            push;
  logic [LVL_W-1:0] level;
  logic [LVL_W:0]   committed;

  // Stall when the queue could not take two words from the input register
  assign committed  = (LVL_W+1)'(level) + ((LVL_W+1)'(busy) << 1);
  assign in_stall_o = committed > (LVL_W+1)'(OUT_DEPTH - 2);
  assign accept     = in_valid_i && !in_stall_o;

  rdc_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .busy_o     (busy),
    .push_o     (push)
  );

  rdc_out_fifo #(
    .DEPTH (OUT_DEPTH),
    .LVL_W (LVL_W)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/rdc_parser.sv
// Configuration registers, input register, record state and per-word parse logic of the deframer.
// Depends on rdc_pkg and the assertion macros header.
`include "record_deframer_crc32_check_macros.svh"

module rdc_parser #(
  parameter int unsigned LEN_BITS = rdc_pkg::LEN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  rdc_pkg::in_word_t               in_data_i,
  output logic                            busy_o,
  output rdc_pkg::push_t                  push_o
);
  import rdc_pkg::*;

  localparam int unsigned IDX_W = LEN_BITS + 2;
  localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] HDR_END  = IDX_W'(HDR_BYTES);
  localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_BYTES - 1);
  localparam logic [IDX_W-1:0] TRAILER  = IDX_W'(HDR_BYTES + CRC_BYTES);

  logic [31:0]      magic_q;
  logic [15:0]      version_q;
  logic             s1_valid_q;
  in_word_t         s1_data_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [127:0]     hdr_q, hdr_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      rc_q, rc_d;
  logic             disc_q, disc_d;
  logic [IDX_W-1:0] key_end_q, pay_end_q, rec_end_q;
  logic [IDX_W-1:0] key_end_d, pay_end_d, rec_end_d;
  logic             ends_load;

  logic [127:0]     hdr_shift;
  logic [31:0]      crc_next;
  logic [31:0]      rc_shift;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] kl_new, vl_new;
  status_e          st;
  logic             clr;
  push_t            push;

  // Build a verdict word from a header image
  function automatic out_word_t make_verdict(status_e s, logic hdr_in, logic [127:0] h,
                                             logic [33:0] bc);
    out_word_t w;
    w = '0;
    w.kind   = KIND_VERDICT;
    w.status = s;
    w.last   = 1'b1;
    if (hdr_in) begin
      w.record_kind    = h[79:64];
      w.key_length     = h[63:32] & LEN_MASK;
      w.value_length   = h[31:0] & LEN_MASK;
      w.bytes_consumed = bc;
    end
    return w;
  endfunction

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RESET;
      version_q <= VERSION_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MAGIC:   magic_q   <= cfg_data_i;
        REG_VERSION: version_q <= cfg_data_i[15:0];
        default:     ;
      endcase
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_data_q <= in_data_i;
    end
  end

  assign busy_o = s1_valid_q;

  // Shared next values for the current word
  assign hdr_shift = {hdr_q[119:0], s1_data_q.data_byte};
  assign crc_next  = crc32_byte(crc_q, s1_data_q.data_byte);
  assign rc_shift  = {rc_q[23:0], s1_data_q.data_byte};
  assign idx_inc   = idx_q + IDX_W'(1);
  assign kl_new    = IDX_W'(hdr_shift[63:32] & LEN_MASK);
  assign vl_new    = IDX_W'(hdr_shift[31:0] & LEN_MASK);

  // Record boundaries, fixed once the header is complete
  assign key_end_d = HDR_END + kl_new;
  assign pay_end_d = HDR_END + kl_new + vl_new;
  assign rec_end_d = TRAILER + kl_new + vl_new;

  // Parse one word: header, payload, trailer, or discard
  always_comb begin
    disc_d    = disc_q;
    idx_d     = idx_q;
    hdr_d     = hdr_q;
    crc_d     = crc_q;
    rc_d      = rc_q;
    push      = '0;
    clr       = 1'b0;
    ends_load = 1'b0;
    st        = ST_OK;
    if (s1_valid_q) begin
      if (disc_q) begin
        if (s1_data_q.buffer_end) begin
          disc_d = 1'b0;
          clr    = 1'b1;
        end
      end else if (idx_q < HDR_END) begin
        hdr_d = hdr_shift;
        crc_d = crc_next;
        idx_d = idx_inc;
        if (idx_q != HDR_LAST) begin
          if (s1_data_q.buffer_end) begin
            push.n  = 2'd1;
            push.w0 = make_verdict(ST_TRUNCATED, 1'b0, hdr_shift, '0);
            clr     = 1'b1;
          end
        end else begin
          ends_load = 1'b1;
          if (hdr_shift[127:96] != magic_q) begin
            st = ST_BAD_MAGIC;
          end else if (hdr_shift[95:80] != version_q) begin
            st = ST_BAD_VERSION;
          end else if (hdr_shift[79:64] != TYPE_PUT && hdr_shift[79:64] != TYPE_DELETE) begin
            st = ST_BAD_TYPE;
          end else if (s1_data_q.buffer_end) begin
            st = ST_TRUNCATED;
          end
          if (st != ST_OK) begin
            push.n  = 2'd1;
            push.w0 = make_verdict(st, 1'b1, hdr_shift, '0);
            if (!s1_data_q.buffer_end && st != ST_TRUNCATED) begin
              disc_d = 1'b1;
            end
            clr = 1'b1;
          end
        end
      end else if (idx_q < pay_end_q) begin
        crc_d = crc_next;
        idx_d = idx_inc;
        push.n               = 2'd1;
        push.w0              = '0;
        push.w0.kind         = (idx_q < key_end_q) ? KIND_KEY : KIND_VALUE;
        push.w0.payload_byte = s1_data_q.data_byte;
        push.w0.status       = ST_OK;
        push.w0.last         = !s1_data_q.buffer_end;
        if (s1_data_q.buffer_end) begin
          push.n  = 2'd2;
          push.w1 = make_verdict(ST_TRUNCATED, 1'b1, hdr_q, '0);
          clr     = 1'b1;
        end
      end else begin
        rc_d  = rc_shift;
        idx_d = idx_inc;
        if (idx_inc < rec_end_q) begin
          if (s1_data_q.buffer_end) begin
            push.n  = 2'd1;
            push.w0 = make_verdict(ST_TRUNCATED, 1'b1, hdr_q, '0);
            clr     = 1'b1;
          end
        end else begin
          push.n = 2'd1;
          if ((crc_q ^ CRC_ALL_ONES) == rc_shift) begin
            push.w0 = make_verdict(ST_OK, 1'b1, hdr_q, 34'(rec_end_q));
          end else begin
            push.w0 = make_verdict(ST_CRC, 1'b1, hdr_q, '0);
          end
          clr = 1'b1;
        end
      end
    end
    if (clr) begin
      idx_d = '0;
      hdr_d = '0;
      crc_d = CRC_ALL_ONES;
      rc_d  = '0;
    end
  end

  assign push_o = push;

  // Hold the record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hdr_q  <= '0;
      crc_q  <= CRC_ALL_ONES;
      rc_q   <= '0;
      disc_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      hdr_q  <= hdr_d;
      crc_q  <= crc_d;
      rc_q   <= rc_d;
      disc_q <= disc_d;
    end
  end

  // Latch record boundaries at the last header byte
  always_ff @(posedge clk_i) begin
    if (ends_load) begin
      key_end_q <= key_end_d;
      pay_end_q <= pay_end_d;
      rec_end_q <= rec_end_d;
    end
  end

  `RDC_ASSERT(two_results_a, (push_o.n == 2'd2) |-> (push_o.w0.kind != KIND_VERDICT && push_o.w1.kind == KIND_VERDICT && push_o.w1.status == ST_TRUNCATED), "double result must be payload then truncated verdict")
  `RDC_ASSERT(discard_clear_a, disc_q |-> (idx_q == '0 && crc_q == CRC_ALL_ONES), "record state not cleared while discarding")
  `RDC_ASSERT(ok_count_a, (push_o.n != 2'd0 && push_o.w0.kind == KIND_VERDICT && push_o.w0.status == ST_OK) |-> (push_o.w0.bytes_consumed >= 34'(TRAILER)), "ok verdict with short byte count")

endmodule

>>> rtl/rdc_out_fifo.sv
// Result queue of the deframer: takes up to two words per cycle, gives one unless stalled.
// Depends on rdc_pkg and the assertion macros header.
`include "record_deframer_crc32_check_macros.svh"

module rdc_out_fifo #(
  parameter int unsigned DEPTH = rdc_pkg::OUT_DEPTH_DEF,
  parameter int unsigned LVL_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rdc_pkg::push_t       push_i,
  output logic [LVL_W-1:0]     level_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rdc_pkg::out_word_t   out_data_o
);
  import rdc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  out_word_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W-1:0] wr_next, wr_next2;
  logic [LVL_W-1:0] level_q, level_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop      = out_valid_o && !out_stall_i;
  assign wr_next  = ptr_inc(wr_q);
  assign wr_next2 = ptr_inc(wr_next);

  // Advance pointers and fill level
  always_comb begin
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    wr_d    = wr_q;
    level_d = level_q + LVL_W'(push_i.n) - LVL_W'(pop);
    case (push_i.n)
      2'd1:    wr_d = wr_next;
      2'd2:    wr_d = wr_next2;
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  // Store the pushed words
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.w0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.w1;
    end
  end

  assign level_o     = level_q;
  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rd_q];

  `RDC_ASSERT_ALWAYS(level_max_a, (!rst_ni) || (level_q <= LVL_W'(DEPTH)), "result queue over depth")
  `RDC_ASSERT(no_overflow_a, ({1'b0, level_q} + (LVL_W+1)'(push_i.n)) <= ((LVL_W+1)'(DEPTH) + (LVL_W+1)'(pop)), "push into full result queue")
  `RDC_ASSERT(drain_a, (level_q == LVL_W'(1) && pop && push_i.n == 2'd0) |=> !out_valid_o, "queue not empty after last word taken")

endmodule
